// ===== rtl/lspq_pkg.sv =====
// Shared types and constants of the linear-scan priority queue.
package lspq_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int PAYLOAD_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH       = 2;

	typedef enum logic [1:0] {
		OP_PUSH      = 2'd0,
		OP_PUSH_ZERO = 2'd1,
		OP_POP       = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ZERO  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		BK_IDLE = 1'b0,
		BK_SCAN = 1'b1
	} bk_state_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_ctl_t;

endpackage

// ===== rtl/lspq_in_if.sv =====
// Request channel: command, job priority and job payload.
interface lspq_in_if #(
	parameter int PRIORITY_BITS = lspq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = lspq_pkg::PAYLOAD_BITS_DEF
) ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [PRIORITY_BITS-1:0] job_priority;
	logic [PAYLOAD_BITS-1:0]  job_payload;

	modport source (output valid, output command, output job_priority, output job_payload,
		input ready);
	modport sink (input valid, input command, input job_priority, input job_payload,
		output ready);
endinterface

// ===== rtl/lspq_out_if.sv =====
// Response channel: status, dequeued job, fill level and head job.
interface lspq_out_if #(
	parameter int PRIORITY_BITS = lspq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = lspq_pkg::PAYLOAD_BITS_DEF,
	parameter int CNT_BITS      = $clog2(lspq_pkg::DEPTH_DEF + 1)
) ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic                     out_valid;
	logic [PRIORITY_BITS-1:0] out_priority;
	logic [PAYLOAD_BITS-1:0]  out_payload;
	logic [CNT_BITS-1:0]      count;
	logic [CNT_BITS-1:0]      space;
	logic                     head_valid;
	logic [PRIORITY_BITS-1:0] head_priority;
	logic [PAYLOAD_BITS-1:0]  head_payload;

	modport source (output valid, output status, output out_valid, output out_priority,
		output out_payload, output count, output space, output head_valid,
		output head_priority, output head_payload, input ready);
	modport sink (input valid, input status, input out_valid, input out_priority,
		input out_payload, input count, input space, input head_valid,
		input head_priority, input head_payload, output ready);
endinterface

// ===== rtl/lspq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/lspq_front.sv =====
// Front end: accept requests, classify them and queue them for the back end.
module lspq_front #(
	parameter int PRIORITY_BITS = lspq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = lspq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	lspq_in_if.sink                  req,
	output lspq_pkg::cmd_ctl_t       cmd_ctl,
	input  logic                     cmd_ready,
	output logic [PRIORITY_BITS-1:0] cmd_pri,
	output logic [PAYLOAD_BITS-1:0]  cmd_pay
);
	localparam int QD        = lspq_pkg::QUEUE_DEPTH;
	localparam int QPTR_BITS = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCNT_BITS = $clog2(QD + 1);
	localparam logic [QCNT_BITS-1:0] QD_C   = QCNT_BITS'(QD);
	localparam logic [QPTR_BITS-1:0] QLAST_C = QPTR_BITS'(QD - 1);

	lspq_pkg::op_t            op_q  [QD];
	logic [PRIORITY_BITS-1:0] pri_q [QD];
	logic [PAYLOAD_BITS-1:0]  pay_q [QD];
	logic [QPTR_BITS-1:0]     wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0]     cnt_q;
	lspq_pkg::op_t            op_in;
	logic                     push, pop;

	always_comb begin
		if (req.command) begin
			op_in = lspq_pkg::OP_POP;
		end else if (req.job_priority == '0) begin
			op_in = lspq_pkg::OP_PUSH_ZERO;
		end else begin
			op_in = lspq_pkg::OP_PUSH;
		end
	end

	assign req.ready     = (cnt_q != QD_C);
	assign push          = req.valid && req.ready;
	assign cmd_ctl.valid = (cnt_q != '0);
	assign cmd_ctl.op    = op_q[rd_ptr_q];
	assign cmd_pri       = pri_q[rd_ptr_q];
	assign cmd_pay       = pay_q[rd_ptr_q];
	assign pop           = cmd_ctl.valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op_in;
			pri_q[wr_ptr_q] <= req.job_priority;
			pay_q[wr_ptr_q] <= req.job_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QLAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QLAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= QD_C)
		else $error("queue count beyond depth");
	a_ptr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers differ on empty queue");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && cnt_q == '0) |=> cmd_ctl.valid)
		else $error("queued item not presented");
endmodule

// ===== rtl/lspq_back.sv =====
// Back end: job store, enqueue, dequeue with shift-and-rescan, response register.
module lspq_back #(
	parameter int DEPTH         = lspq_pkg::DEPTH_DEF,
	parameter int PRIORITY_BITS = lspq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = lspq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lspq_pkg::cmd_ctl_t       cmd_ctl,
	output logic                     cmd_ready,
	input  logic [PRIORITY_BITS-1:0] cmd_pri,
	input  logic [PAYLOAD_BITS-1:0]  cmd_pay,
	lspq_out_if.source               rsp
);
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int ENTRY_BITS = PRIORITY_BITS + PAYLOAD_BITS;
	localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(DEPTH);

	lspq_pkg::bk_state_t state_q, state_d;

	logic                     take, issue, scan_end;
	logic [CNT_BITS-1:0]      occ_q;
	logic                     head_valid_q;
	logic [PRIORITY_BITS-1:0] head_pri_q;
	logic [PAYLOAD_BITS-1:0]  head_pay_q;
	logic [IDX_BITS-1:0]      head_idx_q;

	logic [CNT_BITS-1:0]      rd_idx_q;
	logic                     rd_valid_s1;
	logic [IDX_BITS-1:0]      rd_j_s1;
	logic                     best_valid_q;
	logic [PRIORITY_BITS-1:0] best_pri_q;
	logic [PAYLOAD_BITS-1:0]  best_pay_q;
	logic [IDX_BITS-1:0]      best_idx_q;

	logic                     res_valid_q;
	lspq_pkg::status_t        res_status_q;
	logic                     res_out_valid_q;
	logic [PRIORITY_BITS-1:0] res_out_pri_q;
	logic [PAYLOAD_BITS-1:0]  res_out_pay_q;
	logic [CNT_BITS-1:0]      res_count_q, res_space_q;
	logic                     res_head_valid_q;
	logic [PRIORITY_BITS-1:0] res_head_pri_q;
	logic [PAYLOAD_BITS-1:0]  res_head_pay_q;

	logic                     full, empty, push_ok, pop_start, take_head;
	lspq_pkg::status_t        status_c;
	logic [CNT_BITS-1:0]      count_n;
	logic                     hv_n;
	logic [PRIORITY_BITS-1:0] hp_n;
	logic [PAYLOAD_BITS-1:0]  hy_n;

	logic                     ram_we;
	logic [IDX_BITS-1:0]      ram_waddr;
	logic [ENTRY_BITS-1:0]    ram_wdata, ram_rdata;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic [PAYLOAD_BITS-1:0]  rd_pay;
	logic                     cand, cand_shift, cand_better;
	logic [IDX_BITS-1:0]      cand_idx;

	lspq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[IDX_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lspq_pkg::BK_IDLE: begin
				if (pop_start) begin
					state_d = lspq_pkg::BK_SCAN;
				end
			end
			lspq_pkg::BK_SCAN: begin
				if (scan_end) begin
					state_d = lspq_pkg::BK_IDLE;
				end
			end
			default: state_d = lspq_pkg::BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		cmd_ready = 1'b0;
		issue     = 1'b0;
		scan_end  = 1'b0;
		case (state_q)
			lspq_pkg::BK_IDLE: begin
				cmd_ready = !res_valid_q || rsp.ready;
			end
			lspq_pkg::BK_SCAN: begin
				issue    = (rd_idx_q != occ_q);
				scan_end = (rd_idx_q == occ_q) && !rd_valid_s1;
			end
			default: ;
		endcase
	end

	assign take      = cmd_ctl.valid && cmd_ready;
	assign full      = (occ_q == DEPTH_C);
	assign empty     = (occ_q == '0);
	assign push_ok   = take && (cmd_ctl.op == lspq_pkg::OP_PUSH) && !full;
	assign pop_start = take && (cmd_ctl.op == lspq_pkg::OP_POP) && !empty;
	assign take_head = push_ok && (!head_valid_q || cmd_pri < head_pri_q);

	always_comb begin
		case (cmd_ctl.op)
			lspq_pkg::OP_POP:       status_c = empty ? lspq_pkg::ST_EMPTY : lspq_pkg::ST_OK;
			lspq_pkg::OP_PUSH_ZERO: status_c = full ? lspq_pkg::ST_FULL : lspq_pkg::ST_ZERO;
			lspq_pkg::OP_PUSH:      status_c = full ? lspq_pkg::ST_FULL : lspq_pkg::ST_OK;
			default:                status_c = lspq_pkg::ST_OK;
		endcase
		count_n = push_ok ? occ_q + 1'b1 : occ_q;
		hv_n    = head_valid_q || push_ok;
		hp_n    = take_head ? cmd_pri : head_pri_q;
		hy_n    = take_head ? cmd_pay : head_pay_q;
	end

	// compare stage of the scan; entries behind the removed slot move down one
	assign rd_pri      = ram_rdata[ENTRY_BITS-1:PAYLOAD_BITS];
	assign rd_pay      = ram_rdata[PAYLOAD_BITS-1:0];
	assign cand        = rd_valid_s1 && (rd_j_s1 != head_idx_q);
	assign cand_shift  = rd_valid_s1 && (rd_j_s1 > head_idx_q);
	assign cand_idx    = cand_shift ? rd_j_s1 - 1'b1 : rd_j_s1;
	assign cand_better = cand && (!best_valid_q || rd_pri < best_pri_q);

	always_comb begin
		if (cand_shift) begin
			ram_we    = 1'b1;
			ram_waddr = cand_idx;
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = push_ok;
			ram_waddr = occ_q[IDX_BITS-1:0];
			ram_wdata = {cmd_pri, cmd_pay};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lspq_pkg::BK_IDLE;
			occ_q        <= '0;
			head_valid_q <= 1'b0;
			rd_idx_q     <= '0;
			rd_valid_s1  <= 1'b0;
			best_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (pop_start) begin
				rd_idx_q     <= '0;
				best_valid_q <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (cand_better) begin
					best_valid_q <= 1'b1;
				end
			end
			if (push_ok) begin
				occ_q        <= occ_q + 1'b1;
				head_valid_q <= 1'b1;
			end else if (scan_end) begin
				occ_q        <= occ_q - 1'b1;
				head_valid_q <= best_valid_q;
			end
			if ((take && !pop_start) || scan_end) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_j_s1 <= rd_idx_q[IDX_BITS-1:0];
		end
		if (cand_better) begin
			best_pri_q <= rd_pri;
			best_pay_q <= rd_pay;
			best_idx_q <= cand_idx;
		end
		if (take_head) begin
			head_pri_q <= cmd_pri;
			head_pay_q <= cmd_pay;
			head_idx_q <= occ_q[IDX_BITS-1:0];
		end else if (scan_end) begin
			head_pri_q <= best_pri_q;
			head_pay_q <= best_pay_q;
			head_idx_q <= best_idx_q;
		end
		if (take) begin
			res_status_q     <= status_c;
			res_out_valid_q  <= pop_start;
			res_out_pri_q    <= pop_start ? head_pri_q : '0;
			res_out_pay_q    <= pop_start ? head_pay_q : '0;
			res_count_q      <= count_n;
			res_space_q      <= DEPTH_C - count_n;
			res_head_valid_q <= hv_n;
			res_head_pri_q   <= hv_n ? hp_n : '0;
			res_head_pay_q   <= hv_n ? hy_n : '0;
		end else if (scan_end) begin
			res_count_q      <= occ_q - 1'b1;
			res_space_q      <= DEPTH_C - (occ_q - 1'b1);
			res_head_valid_q <= best_valid_q;
			res_head_pri_q   <= best_valid_q ? best_pri_q : '0;
			res_head_pay_q   <= best_valid_q ? best_pay_q : '0;
		end
	end

	assign rsp.valid         = res_valid_q;
	assign rsp.status        = res_status_q;
	assign rsp.out_valid     = res_out_valid_q;
	assign rsp.out_priority  = res_out_pri_q;
	assign rsp.out_payload   = res_out_pay_q;
	assign rsp.count         = res_count_q;
	assign rsp.space         = res_space_q;
	assign rsp.head_valid    = res_head_valid_q;
	assign rsp.head_priority = res_head_pri_q;
	assign rsp.head_payload  = res_head_pay_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n) occ_q <= DEPTH_C)
		else $error("occupancy beyond depth");
	a_head_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lspq_pkg::BK_IDLE) |-> (head_valid_q == (occ_q != '0)))
		else $error("head flag disagrees with occupancy");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lspq_pkg::BK_SCAN) |-> !res_valid_q)
		else $error("response pending during scan");
	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		scan_end |=> (occ_q == $past(occ_q) - 1'b1))
		else $error("dequeue did not remove one job");
endmodule

// ===== rtl/linear_scan_priority_queue_core.sv =====
// Top level of the linear-scan priority queue: request front end and job back end.
//
//   channel  dir  handshake        payload
//   req      in   valid / ready    command, job_priority, job_payload
//   rsp      out  valid / ready    status, out_*, count, space, head_*
//
// Enqueue and rejected requests: response is valid in the cycle after the back end takes the item.
// Dequeue: the response follows a read-shift-compare pass over the job RAM.
// A two-item queue sits between front and back; the response register holds while stalled.
// Reset clears control state only; RAM data past the fill count is never used by the scan.
module linear_scan_priority_queue_core #(
	parameter int DEPTH         = lspq_pkg::DEPTH_DEF,
	parameter int PRIORITY_BITS = lspq_pkg::PRIORITY_BITS_DEF,
	parameter int PAYLOAD_BITS  = lspq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lspq_in_if.sink    req,
	lspq_out_if.source rsp
);
	lspq_pkg::cmd_ctl_t       cmd_ctl;
	logic                     cmd_ready;
	logic [PRIORITY_BITS-1:0] cmd_pri;
	logic [PAYLOAD_BITS-1:0]  cmd_pay;

	lspq_front #(
		.PRIORITY_BITS (PRIORITY_BITS),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_ctl   (cmd_ctl),
		.cmd_ready (cmd_ready),
		.cmd_pri   (cmd_pri),
		.cmd_pay   (cmd_pay)
	);

	lspq_back #(
		.DEPTH         (DEPTH),
		.PRIORITY_BITS (PRIORITY_BITS),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ctl   (cmd_ctl),
		.cmd_ready (cmd_ready),
		.cmd_pri   (cmd_pri),
		.cmd_pay   (cmd_pay),
		.rsp       (rsp)
	);
endmodule
